### rtl/core/assert_macros.svh
// concurrent assertion helpers, clocked with asynchronous active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");

`endif

### rtl/core/rfd_pkg.sv
package rfd_pkg;

	localparam int NUM_KEYS  = 15;
	localparam int TIME_BITS = 32;
	localparam int NUM_SLOTS = NUM_KEYS + 2;

	localparam int FRAME_W   = 64;
	localparam int NOW_W     = 32;
	localparam int STICK_W   = 11;
	localparam int NUM_STICKS = 4;
	localparam int SWITCH_W  = 4;
	localparam int AXIS_W    = 16;
	localparam int NUM_AXES  = 3;
	localparam int BUTTON_W  = 2;
	localparam int KEY_W     = 16;
	localparam int EDGE_W    = 17;
	localparam int LOCKOUT_W = 16;

	localparam int LEFT_EDGE_BIT  = 15;
	localparam int RIGHT_EDGE_BIT = 16;

	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd50;
	localparam logic [STICK_W-1:0]   STICK_OFFSET  = 11'h400;

	// right switch code, off means the frame is not taken
	typedef enum logic [1:0] {
		RSW_OFF  = 2'd0,
		RSW_UP   = 2'd1,
		RSW_DOWN = 2'd2,
		RSW_MID  = 2'd3
	} rsw_code_t;

endpackage

### rtl/core/remote_frame_decode_with_key_edges.sv
// a frame passes through the input register and then the result register before it is on the outputs
// throughput: one frame per cycle while the output is not stalled, set by the input register and the result register
// decode and the 17 parallel lockout compares fit between the two registers
// a stalled result holds both stages and stalls the input
// reset: pipeline empty, held record and press times cleared, lockout set to 50 ms
module remote_frame_decode_with_key_edges (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_wr_en,
	input  logic        [rfd_pkg::LOCKOUT_W-1:0]        cfg_wr_data,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic        [rfd_pkg::FRAME_W-1:0]          frame_low,
	input  logic        [rfd_pkg::FRAME_W-1:0]          frame_high,
	input  logic        [rfd_pkg::NOW_W-1:0]            now_ms,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic signed [rfd_pkg::STICK_W-1:0]          stick_1,
	output logic signed [rfd_pkg::STICK_W-1:0]          stick_2,
	output logic signed [rfd_pkg::STICK_W-1:0]          stick_3,
	output logic signed [rfd_pkg::STICK_W-1:0]          stick_4,
	output logic        [rfd_pkg::SWITCH_W-1:0]         switches,
	output logic signed [rfd_pkg::AXIS_W-1:0]           mouse_dx,
	output logic signed [rfd_pkg::AXIS_W-1:0]           mouse_dy,
	output logic signed [rfd_pkg::AXIS_W-1:0]           mouse_dz,
	output logic        [rfd_pkg::BUTTON_W-1:0]         mouse_buttons,
	output logic        [rfd_pkg::KEY_W-1:0]            key_mask,
	output logic        [rfd_pkg::EDGE_W-1:0]           press_edges,
	output logic                                        frame_ok
);
	import rfd_pkg::*;

	logic                    valid_s1;
	logic [FRAME_W-1:0]      frame_low_s1;
	logic [FRAME_W-1:0]      frame_high_s1;
	logic [TIME_BITS-1:0]    now_s1;

	logic                    valid_s2;
	logic [EDGE_W-1:0]       edges_s2;
	logic                    ok_s2;

	logic [LOCKOUT_W-1:0]    lockout_q;
	logic [STICK_W-1:0]      sticks_q [NUM_STICKS];
	logic [SWITCH_W-1:0]     switches_q;
	logic [AXIS_W-1:0]       axes_q [NUM_AXES];
	logic [BUTTON_W-1:0]     buttons_q;
	logic [KEY_W-1:0]        keys_q;
	logic [TIME_BITS-1:0]    press_time_q [NUM_SLOTS];

	logic                    adv;
	logic                    in_xfer;
	rsw_code_t               rsw_code;
	logic                    ok_d;
	logic [KEY_W-1:0]        keys_d;
	logic [BUTTON_W-1:0]     buttons_d;
	logic [STICK_W-1:0]      sticks_d [NUM_STICKS];
	logic [AXIS_W-1:0]       axes_d [NUM_AXES];
	logic [NUM_SLOTS-1:0]    slot_on;
	logic [NUM_SLOTS-1:0]    slot_was;
	logic [NUM_SLOTS-1:0]    hit;
	logic [EDGE_W-1:0]       edges_d;

	// output register frees up or moves on this cycle
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	// frame decode
	assign rsw_code  = rsw_code_t'(frame_low_s1[45:44]);
	assign ok_d      = (rsw_code != RSW_OFF);
	assign keys_d    = frame_high_s1[63:48];
	assign buttons_d = {|frame_high_s1[47:40], |frame_high_s1[39:32]};
	assign axes_d[0] = frame_low_s1[63:48];
	assign axes_d[1] = frame_high_s1[15:0];
	assign axes_d[2] = frame_high_s1[31:16];

	always_comb begin
		for (int j = 0; j < NUM_STICKS; j++) begin
			sticks_d[j] = frame_low_s1[STICK_W*j +: STICK_W] ^ STICK_OFFSET;
		end
	end

	// press edges with per-slot lockout
	always_comb begin
		logic [TIME_BITS-1:0] elapsed;
		slot_on  = '0;
		slot_was = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			slot_on[k]  = keys_d[k];
			slot_was[k] = keys_q[k];
		end
		slot_on[NUM_KEYS]    = buttons_d[0];
		slot_was[NUM_KEYS]   = buttons_q[0];
		slot_on[NUM_KEYS+1]  = buttons_d[1];
		slot_was[NUM_KEYS+1] = buttons_q[1];
		for (int i = 0; i < NUM_SLOTS; i++) begin
			elapsed = now_s1 - press_time_q[i];
			hit[i]  = ok_d && slot_on[i] && !slot_was[i] &&
				(elapsed >= TIME_BITS'(lockout_q));
		end
	end

	always_comb begin
		edges_d = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			edges_d[k] = hit[k];
		end
		edges_d[LEFT_EDGE_BIT]  = edges_d[LEFT_EDGE_BIT] | hit[NUM_KEYS];
		edges_d[RIGHT_EDGE_BIT] = hit[NUM_KEYS+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RESET;
		end else if (cfg_wr_en) begin
			lockout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			frame_low_s1  <= frame_low;
			frame_high_s1 <= frame_high;
			now_s1        <= now_ms[TIME_BITS-1:0];
		end
		if (adv) begin
			edges_s2 <= edges_d;
			ok_s2    <= ok_d;
		end
	end

	// held record doubles as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_STICKS; j++) begin
				sticks_q[j] <= '0;
			end
			for (int a = 0; a < NUM_AXES; a++) begin
				axes_q[a] <= '0;
			end
			switches_q <= '0;
			buttons_q  <= '0;
			keys_q     <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				press_time_q[i] <= '0;
			end
		end else if (adv && ok_d) begin
			for (int j = 0; j < NUM_STICKS; j++) begin
				sticks_q[j] <= sticks_d[j];
			end
			for (int a = 0; a < NUM_AXES; a++) begin
				axes_q[a] <= axes_d[a];
			end
			switches_q <= frame_low_s1[47:44];
			buttons_q  <= buttons_d;
			keys_q     <= keys_d;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (hit[i]) begin
					press_time_q[i] <= now_s1;
				end
			end
		end
	end

	assign out_valid     = valid_s2;
	assign stick_1       = sticks_q[0];
	assign stick_2       = sticks_q[1];
	assign stick_3       = sticks_q[2];
	assign stick_4       = sticks_q[3];
	assign switches      = switches_q;
	assign mouse_dx      = axes_q[0];
	assign mouse_dy      = axes_q[1];
	assign mouse_dz      = axes_q[2];
	assign mouse_buttons = buttons_q;
	assign key_mask      = keys_q;
	assign press_edges   = edges_s2;
	assign frame_ok      = ok_s2;

endmodule

### rtl/core/rfd_checker.sv
`include "assert_macros.svh"

module rfd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [rfd_pkg::STICK_W-1:0]   stick_1,
	input logic        [rfd_pkg::SWITCH_W-1:0]  switches,
	input logic signed [rfd_pkg::AXIS_W-1:0]    mouse_dx,
	input logic        [rfd_pkg::BUTTON_W-1:0]  mouse_buttons,
	input logic        [rfd_pkg::KEY_W-1:0]     key_mask,
	input logic        [rfd_pkg::EDGE_W-1:0]    press_edges,
	input logic                                 frame_ok
);
	import rfd_pkg::*;

	// a stalled result holds
	`ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(stick_1) && $stable(switches) && $stable(mouse_dx) && $stable(key_mask) && $stable(press_edges) && $stable(frame_ok))

	// a held record never reports edges
	`ASSERT_PROP(a_reject_no_edge, clk, arst_n, out_valid && !frame_ok |-> press_edges == '0)

	// mouse edges only with the button pressed in the same record (the left check also accepts key_mask bit 15)
	`ASSERT_PROP(a_left_edge_pressed, clk, arst_n, out_valid && press_edges[LEFT_EDGE_BIT] |-> mouse_buttons[0] || key_mask[LEFT_EDGE_BIT])
	`ASSERT_PROP(a_right_edge_pressed, clk, arst_n, out_valid && press_edges[RIGHT_EDGE_BIT] |-> mouse_buttons[1])

endmodule

bind remote_frame_decode_with_key_edges rfd_checker u_rfd_checker (.*);
